FILE: rtl/pbsc_pkg.sv
// Package for the plane/box side classifier.
// Holds field widths, side codes and configuration register indexes.
// No dependencies.
package pbsc_pkg;

    localparam int COORD_W = 32;
    localparam int NRM_W   = 18;
    localparam int OFF_W   = 32;
    localparam int PROD_W  = COORD_W + NRM_W;     // exact product
    localparam int DOT_W   = PROD_W + 2;          // sum of three products
    localparam int CMP_W   = DOT_W + 4;           // s +/- r and scaled offset
    localparam int FRAC_W  = 16;                  // fraction bits of the Q2.16 normal
    localparam int IDX_W   = 2;
    localparam int SIDE_W  = 2;

    localparam logic [IDX_W-1:0] REG_NORMAL_X     = 2'd0;
    localparam logic [IDX_W-1:0] REG_NORMAL_Y     = 2'd1;
    localparam logic [IDX_W-1:0] REG_NORMAL_Z     = 2'd2;
    localparam logic [IDX_W-1:0] REG_PLANE_OFFSET = 2'd3;

    localparam logic signed [NRM_W-1:0] NORMAL_Z_RESET = 18'sh10000;

    localparam logic [SIDE_W-1:0] SIDE_BEHIND  = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_CROSSES = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_FRONT   = 2'd2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [NRM_W-1:0]   nrm_t;
    typedef logic signed [DOT_W-1:0]   dot_t;

    typedef struct packed {
        nrm_t x;
        nrm_t y;
        nrm_t z;
    } normal_t;

endpackage

FILE: rtl/pbsc_dot_lane.sv
// One dot-product lane: vector . plane normal, exact.
// Two stages: three registered multipliers, then a registered three-way sum.
// Depends on pbsc_pkg.
module pbsc_dot_lane
    import pbsc_pkg::*;
(
    input  logic    clk,
    input  coord_t  vx,
    input  coord_t  vy,
    input  coord_t  vz,
    input  normal_t nrm,
    output dot_t    dot
);

    logic signed [PROD_W-1:0] px_reg;
    logic signed [PROD_W-1:0] py_reg;
    logic signed [PROD_W-1:0] pz_reg;
    dot_t                     dot_reg;
    dot_t                     dot_next;

    always_comb
    begin
        dot_next = DOT_W'(px_reg) + DOT_W'(py_reg) + DOT_W'(pz_reg);
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= PROD_W'(vx) * PROD_W'(nrm.x);
        py_reg  <= PROD_W'(vy) * PROD_W'(nrm.y);
        pz_reg  <= PROD_W'(vz) * PROD_W'(nrm.z);
        dot_reg <= dot_next;
    end

    assign dot = dot_reg;

endmodule

FILE: rtl/pbsc_merge.sv
// Merge stage: folds the four lane results into centre distance and radius,
// compares against the scaled plane offset and registers the side code.
// Depends on pbsc_pkg.
module pbsc_merge
    import pbsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  dot_t                      dot_c,
    input  dot_t                      dot_a,
    input  dot_t                      dot_b,
    input  dot_t                      dot_e,
    input  logic signed [OFF_W-1:0]   offset,
    output logic                      done,
    output logic [SIDE_W-1:0]         side
);

    logic signed [CMP_W-1:0] s_reg;
    logic signed [CMP_W-1:0] r_reg;
    logic signed [CMP_W-1:0] r_next;
    logic signed [CMP_W-1:0] abs_a;
    logic signed [CMP_W-1:0] abs_b;
    logic signed [CMP_W-1:0] abs_e;
    logic signed [CMP_W-1:0] d_scaled;
    logic signed [CMP_W-1:0] hi_sum;
    logic signed [CMP_W-1:0] lo_sum;
    logic                    vld_reg;
    logic                    done_reg;
    logic [SIDE_W-1:0]       side_reg;
    logic [SIDE_W-1:0]       side_next;

    always_comb
    begin
        abs_a  = dot_a[DOT_W-1] ? -CMP_W'(dot_a) : CMP_W'(dot_a);
        abs_b  = dot_b[DOT_W-1] ? -CMP_W'(dot_b) : CMP_W'(dot_b);
        abs_e  = dot_e[DOT_W-1] ? -CMP_W'(dot_e) : CMP_W'(dot_e);
        r_next = abs_a + abs_b + abs_e;
    end

    always_comb
    begin
        d_scaled = CMP_W'(offset) <<< FRAC_W;
        hi_sum   = s_reg + r_reg;
        lo_sum   = s_reg - r_reg;
        priority if (hi_sum < d_scaled)
            side_next = SIDE_BEHIND;
        else if (lo_sum < d_scaled)
            side_next = SIDE_CROSSES;
        else
            side_next = SIDE_FRONT;
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= CMP_W'(dot_c);
        r_reg    <= r_next;
        side_reg <= side_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= in_valid;
            done_reg <= vld_reg;
        end
    end

    assign done = done_reg;
    assign side = side_reg;

endmodule

FILE: rtl/plane_box_side_classifier_core.sv
// Plane/box side classifier, top level.
// Instantiates four pbsc_dot_lane copies and pbsc_merge; depends on pbsc_pkg.
//
// Usage:
//   Request channel: drive the box centre and three half-axes and pulse start.
//   A request is taken on any edge with start high; busy is always low, so a
//   new box may be issued every cycle.
//   Result channel: done is high for one cycle with side valid
//   (0 behind, 1 crossing, 2 in front). A request's result passes through
//   the lane product and sum registers, then merge's s/r and side registers;
//   one result per cycle sustained. Results leave in request order.
//   The receiver cannot stall; every result is presented exactly once.
//   Configuration: cfg_valid/cfg_ready write channel, cfg_ready always high.
//   Index 0..2 normal x/y/z (low 18 bits of cfg_data), 3 plane offset.
//   Change the plane only when no request is in flight.
//   Reset: clears the pipeline valids; normal becomes (0,0,1.0), offset 0.
//   Throughput is set by the multiplier stage: twelve 32x18 multipliers,
//   three per lane, all fully pipelined.
module plane_box_side_classifier_core
    import pbsc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  coord_t                  center_x,
    input  coord_t                  center_y,
    input  coord_t                  center_z,
    input  coord_t                  axis_a_x,
    input  coord_t                  axis_a_y,
    input  coord_t                  axis_a_z,
    input  coord_t                  axis_b_x,
    input  coord_t                  axis_b_y,
    input  coord_t                  axis_b_z,
    input  coord_t                  axis_c_x,
    input  coord_t                  axis_c_y,
    input  coord_t                  axis_c_z,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [IDX_W-1:0]        cfg_index,
    input  logic [OFF_W-1:0]        cfg_data,
    output logic                    done,
    output logic [SIDE_W-1:0]       side
);

    normal_t                 nrm_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic                    p1_vld_reg;
    logic                    p2_vld_reg;
    dot_t                    dot_c;
    dot_t                    dot_a;
    dot_t                    dot_b;
    dot_t                    dot_e;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nrm_reg.x <= '0;
            nrm_reg.y <= '0;
            nrm_reg.z <= NORMAL_Z_RESET;
            off_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_NORMAL_X:     nrm_reg.x <= cfg_data[NRM_W-1:0];
                REG_NORMAL_Y:     nrm_reg.y <= cfg_data[NRM_W-1:0];
                REG_NORMAL_Z:     nrm_reg.z <= cfg_data[NRM_W-1:0];
                REG_PLANE_OFFSET: off_reg   <= cfg_data;
                default:          off_reg   <= off_reg;
            endcase
        end
    end

    // valid follows the lanes' multiply and sum stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= start && !busy;
            p2_vld_reg <= p1_vld_reg;
        end
    end

    pbsc_dot_lane u_lane_c (
        .clk (clk),
        .vx  (center_x),
        .vy  (center_y),
        .vz  (center_z),
        .nrm (nrm_reg),
        .dot (dot_c)
    );

    pbsc_dot_lane u_lane_a (
        .clk (clk),
        .vx  (axis_a_x),
        .vy  (axis_a_y),
        .vz  (axis_a_z),
        .nrm (nrm_reg),
        .dot (dot_a)
    );

    pbsc_dot_lane u_lane_b (
        .clk (clk),
        .vx  (axis_b_x),
        .vy  (axis_b_y),
        .vz  (axis_b_z),
        .nrm (nrm_reg),
        .dot (dot_b)
    );

    pbsc_dot_lane u_lane_e (
        .clk (clk),
        .vx  (axis_c_x),
        .vy  (axis_c_y),
        .vz  (axis_c_z),
        .nrm (nrm_reg),
        .dot (dot_e)
    );

    pbsc_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (p2_vld_reg),
        .dot_c    (dot_c),
        .dot_a    (dot_a),
        .dot_b    (dot_b),
        .dot_e    (dot_e),
        .offset   (off_reg),
        .done     (done),
        .side     (side)
    );

endmodule

FILE: rtl/pbsc_checker.sv
// Port-level checker for plane_box_side_classifier_core, with its bind.
// Depends on pbsc_pkg.
module pbsc_checker
    import pbsc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              done,
    input logic [SIDE_W-1:0] side
);

    // every accepted request yields its result
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("request without result");

    // no result without a matching earlier request
    a_done_has_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("spurious result");

    a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (side == SIDE_BEHIND || side == SIDE_CROSSES || side == SIDE_FRONT))
        else $error("bad side code");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

endmodule

bind plane_box_side_classifier_core pbsc_checker u_pbsc_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .side  (side)
);
